/* rtl/core/lrgs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and fixed widths for the linear regression gradient step block.
package lrgs_pkg;

  localparam int DATA_W      = 32;   // Q16.16 sample, target and parameter width
  localparam int ERR_W       = 33;   // target minus saturated prediction
  localparam int PROD_W      = 66;   // signed 33 x 33 product
  localparam int WSUM_W      = 60;   // sum of x * error
  localparam int ESUM_W      = 44;   // sum of error
  localparam int ASUM_W      = 44;   // sum of absolute error
  localparam int LO_W        = 33;   // low partial product after the 31 bit shift
  localparam int QUO_W       = 62;   // scaled step and divider word
  localparam int BSIZE_W     = 11;   // batch size field on the result
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 112;
  localparam int DIV_STEPS   = QUO_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);
  localparam logic [DATA_W-1:0] LR_RESET = 32'd4294967;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_ERR,
    S_MUL2,
    S_ACC,
    S_END,
    S_DIV,
    S_MEAN,
    S_STEP_LO,
    S_STEP_HI,
    S_STEP_LOAD,
    S_STEP_DIV,
    S_APPLY,
    S_EMIT
  } lrgs_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_PRED,
    DP_ERR,
    DP_MUL_WERR,
    DP_ACC,
    DP_DIV_LOAD_MAE,
    DP_DIV_STEP,
    DP_MEAN,
    DP_MUL_LO,
    DP_MUL_HI,
    DP_DIV_LOAD_STEP,
    DP_APPLY,
    DP_EMIT
  } lrgs_op_t;

  typedef struct packed {
    lrgs_op_t op;
    logic     sel;   // 0: slope and weighted error sum, 1: intercept and error sum
  } lrgs_cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
  } lrgs_status_t;

endpackage

/* rtl/core/lrgs_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the gradient step: sample work, batch-end division and update.
module lrgs_ctrl import lrgs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tlast,
  input  logic         in_tuser,
  output logic         in_tready,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  lrgs_status_t status,
  output lrgs_cmd_t    cmd
);

  lrgs_state_t          state_r, state_nxt;
  logic                 last_r, last_nxt;
  logic                 train_r, train_nxt;
  logic                 sel_r, sel_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= 1'b0;
      train_r     <= 1'b0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      train_r     <= train_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    train_nxt     = train_r;
    sel_nxt       = sel_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = DP_NOP;
    cmd.sel       = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = DP_LOAD;
          last_nxt  = in_tlast;
          train_nxt = in_tuser;
          if (status.full) begin
            state_nxt = in_tlast ? S_END : S_IDLE;
          end else begin
            state_nxt = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        cmd.op    = DP_MUL_PRED;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        cmd.op    = DP_ERR;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op    = DP_MUL_WERR;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = DP_ACC;
        state_nxt = last_r ? S_END : S_IDLE;
      end
      S_END: begin
        if (status.cnt_zero) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.op      = DP_DIV_LOAD_MAE;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op      = DP_DIV_STEP;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd.op = DP_MEAN;
        if (train_r) begin
          sel_nxt   = 1'b0;
          state_nxt = S_STEP_LO;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_STEP_LO: begin
        cmd.op    = DP_MUL_LO;
        state_nxt = S_STEP_HI;
      end
      S_STEP_HI: begin
        cmd.op    = DP_MUL_HI;
        state_nxt = S_STEP_LOAD;
      end
      S_STEP_LOAD: begin
        cmd.op      = DP_DIV_LOAD_STEP;
        div_cnt_nxt = '0;
        state_nxt   = S_STEP_DIV;
      end
      S_STEP_DIV: begin
        cmd.op      = DP_DIV_STEP;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.op = DP_APPLY;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_STEP_LO;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.op        = DP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

/* rtl/core/lrgs_dpath.sv */
`timescale 1ns / 1ps
// Datapath: parameters, batch sums, shared multiplier, serial divider, result register.
module lrgs_dpath import lrgs_pkg::*; #(
  parameter int MAX_BATCH = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lrgs_cmd_t           cmd,
  output lrgs_status_t        status,
  input  logic [DATA_W-1:0]   sample_x,
  input  logic [DATA_W-1:0]   target_value,
  input  logic                cfg_we,
  input  logic [DATA_W-1:0]   cfg_wdata,
  output logic [DATA_W-1:0]   new_slope,
  output logic [DATA_W-1:0]   new_intercept,
  output logic [DATA_W-1:0]   mean_abs_error,
  output logic [BSIZE_W-1:0]  batch_size,
  output logic                batch_overflow
);

  localparam int CNT_W = $clog2(MAX_BATCH + 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_BATCH);
  localparam logic [DATA_W-1:0] PARAM_RST = DATA_W'((((1 << FRAC_BITS) + 5) / 10));

  // state with reset
  logic [DATA_W-1:0]        lr_r, lr_nxt;
  logic [DATA_W-1:0]        slope_r, slope_nxt;
  logic [DATA_W-1:0]        icpt_r, icpt_nxt;
  logic signed [WSUM_W-1:0] wsum_r, wsum_nxt;
  logic signed [ESUM_W-1:0] esum_r, esum_nxt;
  logic [ASUM_W-1:0]        asum_r, asum_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [DATA_W-1:0]        mean_r, mean_nxt;
  // working and result registers
  logic [DATA_W-1:0]        x_r, x_nxt;
  logic [DATA_W-1:0]        y_r, y_nxt;
  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [LO_W-1:0]          lo_r, lo_nxt;
  logic [QUO_W-1:0]         dq_r, dq_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic [DATA_W-1:0]        o_slope_r, o_slope_nxt;
  logic [DATA_W-1:0]        o_icpt_r, o_icpt_nxt;
  logic [DATA_W-1:0]        o_mean_r, o_mean_nxt;
  logic [BSIZE_W-1:0]       o_bsize_r, o_bsize_nxt;
  logic                     o_ovf_r, o_ovf_nxt;

  // combinational terms
  logic signed [ERR_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_shr, pred_full, wsum_full;
  logic [DATA_W-1:0]        pred;
  logic [ERR_W-1:0]         aerr;
  logic signed [ESUM_W:0]   esum_full;
  logic [ASUM_W:0]          asum_full;
  logic signed [WSUM_W-1:0] sel_sum;
  logic                     sum_neg;
  logic [WSUM_W-1:0]        sum_mag;
  logic [CNT_W:0]           trial, trial_diff;
  logic                     trial_ge;
  logic [63:0]              q_ext, q_delta;
  logic signed [63:0]       upd_full;
  logic [DATA_W-1:0]        upd_param, upd_base;
  logic [CNT_W+BSIZE_W-1:0] cnt_ext;

  always_comb begin
    prod_shr  = prod_r >>> FRAC_BITS;
    pred_full = prod_shr + {{(PROD_W-DATA_W){icpt_r[DATA_W-1]}}, icpt_r};
    if (pred_full[PROD_W-1:DATA_W-1] == '0 || pred_full[PROD_W-1:DATA_W-1] == '1) begin
      pred = pred_full[DATA_W-1:0];
    end else begin
      pred = pred_full[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    aerr = err_r[ERR_W-1] ? ERR_W'(-err_r) : err_r;

    wsum_full = prod_shr + {{(PROD_W-WSUM_W){wsum_r[WSUM_W-1]}}, wsum_r};
    esum_full = {esum_r[ESUM_W-1], esum_r} + {{(ESUM_W+1-ERR_W){err_r[ERR_W-1]}}, err_r};
    asum_full = {1'b0, asum_r} + {{(ASUM_W+1-ERR_W){1'b0}}, aerr};

    sel_sum = cmd.sel ? {{(WSUM_W-ESUM_W){esum_r[ESUM_W-1]}}, esum_r} : wsum_r;
    sum_neg = sel_sum[WSUM_W-1];
    sum_mag = sum_neg ? WSUM_W'(-sel_sum) : sel_sum;

    trial      = {rem_r, dq_r[QUO_W-1]};
    trial_diff = trial - {1'b0, cnt_r};
    trial_ge   = (trial >= {1'b0, cnt_r});

    upd_base  = cmd.sel ? icpt_r : slope_r;
    q_ext     = {{(64-QUO_W){1'b0}}, dq_r};
    q_delta   = sum_neg ? (~q_ext + 64'd1) : q_ext;
    upd_full  = {{(64-DATA_W){upd_base[DATA_W-1]}}, upd_base} + q_delta;
    if (upd_full[63:DATA_W-1] == '0 || upd_full[63:DATA_W-1] == '1) begin
      upd_param = upd_full[DATA_W-1:0];
    end else begin
      upd_param = upd_full[63] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end

    cnt_ext = {{BSIZE_W{1'b0}}, cnt_r};

    mul_a = {x_r[DATA_W-1], x_r};
    mul_b = {slope_r[DATA_W-1], slope_r};
    case (cmd.op)
      DP_MUL_WERR: begin
        mul_b = err_r;
      end
      DP_MUL_LO: begin
        mul_a = {1'b0, sum_mag[DATA_W-1:0]};
        mul_b = {1'b0, lr_r};
      end
      DP_MUL_HI: begin
        mul_a = {{(ERR_W-(WSUM_W-DATA_W)){1'b0}}, sum_mag[WSUM_W-1:DATA_W]};
        mul_b = {1'b0, lr_r};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    lr_nxt      = cfg_we ? cfg_wdata : lr_r;
    slope_nxt   = slope_r;
    icpt_nxt    = icpt_r;
    wsum_nxt    = wsum_r;
    esum_nxt    = esum_r;
    asum_nxt    = asum_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    mean_nxt    = mean_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    err_nxt     = err_r;
    prod_nxt    = prod_r;
    lo_nxt      = lo_r;
    dq_nxt      = dq_r;
    rem_nxt     = rem_r;
    o_slope_nxt = o_slope_r;
    o_icpt_nxt  = o_icpt_r;
    o_mean_nxt  = o_mean_r;
    o_bsize_nxt = o_bsize_r;
    o_ovf_nxt   = o_ovf_r;
    case (cmd.op)
      DP_LOAD: begin
        x_nxt = sample_x;
        y_nxt = target_value;
        if (cnt_r == CNT_MAX) begin
          ovf_nxt = 1'b1;
        end
      end
      DP_MUL_PRED, DP_MUL_WERR, DP_MUL_LO: begin
        prod_nxt = mul_a * mul_b;
      end
      DP_ERR: begin
        err_nxt = {y_r[DATA_W-1], y_r} - {pred[DATA_W-1], pred};
      end
      DP_ACC: begin
        if (wsum_full[PROD_W-1:WSUM_W-1] == '0 || wsum_full[PROD_W-1:WSUM_W-1] == '1) begin
          wsum_nxt = wsum_full[WSUM_W-1:0];
        end else begin
          wsum_nxt = wsum_full[PROD_W-1] ? {1'b1, {(WSUM_W-1){1'b0}}}
                                         : {1'b0, {(WSUM_W-1){1'b1}}};
        end
        if (esum_full[ESUM_W] == esum_full[ESUM_W-1]) begin
          esum_nxt = esum_full[ESUM_W-1:0];
        end else begin
          esum_nxt = esum_full[ESUM_W] ? {1'b1, {(ESUM_W-1){1'b0}}}
                                       : {1'b0, {(ESUM_W-1){1'b1}}};
        end
        asum_nxt = asum_full[ASUM_W] ? '1 : asum_full[ASUM_W-1:0];
        cnt_nxt  = cnt_r + 1'b1;
      end
      DP_DIV_LOAD_MAE: begin
        dq_nxt  = {{(QUO_W-ASUM_W){1'b0}}, asum_r};
        rem_nxt = '0;
      end
      DP_DIV_STEP: begin
        rem_nxt = trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
        dq_nxt  = {dq_r[QUO_W-2:0], trial_ge};
      end
      DP_MEAN: begin
        mean_nxt = (dq_r[QUO_W-1:DATA_W] != '0) ? '1 : dq_r[DATA_W-1:0];
      end
      DP_MUL_HI: begin
        // keep the low partial product scaled by 2^-31, form the high one
        lo_nxt   = prod_r[63:31];
        prod_nxt = mul_a * mul_b;
      end
      DP_DIV_LOAD_STEP: begin
        dq_nxt  = {prod_r[WSUM_W-1:0], 1'b0} + {{(QUO_W-LO_W){1'b0}}, lo_r};
        rem_nxt = '0;
      end
      DP_APPLY: begin
        if (cmd.sel) begin
          icpt_nxt = upd_param;
        end else begin
          slope_nxt = upd_param;
        end
      end
      DP_EMIT: begin
        o_slope_nxt = slope_r;
        o_icpt_nxt  = icpt_r;
        o_mean_nxt  = mean_r;
        o_bsize_nxt = cnt_ext[BSIZE_W-1:0];
        o_ovf_nxt   = ovf_r;
        wsum_nxt    = '0;
        esum_nxt    = '0;
        asum_nxt    = '0;
        cnt_nxt     = '0;
        ovf_nxt     = 1'b0;
        mean_nxt    = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r    <= LR_RESET;
      slope_r <= PARAM_RST;
      icpt_r  <= PARAM_RST;
      wsum_r  <= '0;
      esum_r  <= '0;
      asum_r  <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      mean_r  <= '0;
    end else begin
      lr_r    <= lr_nxt;
      slope_r <= slope_nxt;
      icpt_r  <= icpt_nxt;
      wsum_r  <= wsum_nxt;
      esum_r  <= esum_nxt;
      asum_r  <= asum_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      mean_r  <= mean_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    err_r     <= err_nxt;
    prod_r    <= prod_nxt;
    lo_r      <= lo_nxt;
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    o_slope_r <= o_slope_nxt;
    o_icpt_r  <= o_icpt_nxt;
    o_mean_r  <= o_mean_nxt;
    o_bsize_r <= o_bsize_nxt;
    o_ovf_r   <= o_ovf_nxt;
  end

  assign status.full     = (cnt_r == CNT_MAX);
  assign status.cnt_zero = (cnt_r == '0);

  assign new_slope      = o_slope_r;
  assign new_intercept  = o_icpt_r;
  assign mean_abs_error = o_mean_r;
  assign batch_size     = o_bsize_r;
  assign batch_overflow = o_ovf_r;

endmodule

/* rtl/core/linear_regression_gradient_step.sv */
`timescale 1ns / 1ps
// Top level of the one-feature linear regression batch gradient step.
//
// Each input beat is one training sample (x, target) in signed Q16.16; the beat
// with tlast closes the batch and produces one result beat carrying the slope
// and intercept after the batch, the mean absolute error measured with the
// parameters held when the batch began, the batch size and an overflow flag.
// Slope and intercept reset to 0.1 and are updated only when tuser is set on
// the closing beat; learning_rate (unsigned Q0.32) is written through cfg_we
// and cfg_wdata; the user must write it only while the block is idle, which
// the block does not enforce. Samples past MAX_BATCH are dropped and reported
// through the overflow flag; a dropped closing beat still ends the batch. One
// shared 33x33 multiplier carries both products of a sample, so a counted
// sample runs prediction multiply, error, weighted-error multiply and
// accumulate before the next ready; a dropped non-closing sample stays idle.
// Batch end runs a one-bit-per-cycle 62-step divider for the mean error, and
// for each of the two scaled steps when training, then loads the output
// register; the input side stalls meanwhile. A finished result waits there
// during the next batch; the next result is held back only until it is taken.
module linear_regression_gradient_step import lrgs_pkg::*; #(
  parameter int MAX_BATCH = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // sample_x [31:0], target_value [63:32]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,   // last_in_batch
  input  logic                   in_tuser,   // train_enable
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // new_slope [31:0], new_intercept [63:32], mean_abs_error [95:64],
  // batch_size [106:96], zero fill [111:107]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,  // batch_overflow
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [DATA_W-1:0]      cfg_wdata
);

  lrgs_cmd_t          cmd;
  lrgs_status_t       status;
  logic [DATA_W-1:0]  new_slope;
  logic [DATA_W-1:0]  new_intercept;
  logic [DATA_W-1:0]  mean_abs_error;
  logic [BSIZE_W-1:0] batch_size;

  // sequencing: accept, per-sample steps, batch-end divide and update
  lrgs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // arithmetic, batch sums and the output holding register
  lrgs_dpath #(
    .MAX_BATCH (MAX_BATCH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .sample_x       (in_tdata[DATA_W-1:0]),
    .target_value   (in_tdata[2*DATA_W-1:DATA_W]),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .new_slope      (new_slope),
    .new_intercept  (new_intercept),
    .mean_abs_error (mean_abs_error),
    .batch_size     (batch_size),
    .batch_overflow (out_tuser)
  );

  // pack the result beat, lowest field first, zero fill to whole bytes
  assign out_tdata = {{(OUT_TDATA_W-3*DATA_W-BSIZE_W){1'b0}},
                      batch_size, mean_abs_error, new_intercept, new_slope};

endmodule

/* rtl/core/lrgs_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the gradient step block, bound to its top level.
module lrgs_checker import lrgs_pkg::*; #(
  parameter int MAX_BATCH = 1024
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready
);

  localparam logic [BSIZE_W-1:0] MAX_LO = BSIZE_W'(MAX_BATCH);
  localparam logic               SIZE_FITS = (MAX_BATCH < (1 << BSIZE_W));

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // a batch always holds at least one sample and never more than the limit
  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && SIZE_FITS |->
      out_tdata[3*DATA_W+BSIZE_W-1:3*DATA_W] != '0 &&
      out_tdata[3*DATA_W+BSIZE_W-1:3*DATA_W] <= MAX_LO)
    else $error("batch size out of range");

  // drops happen only once the batch is full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[3*DATA_W+BSIZE_W-1:3*DATA_W] == MAX_LO)
    else $error("overflow flagged on a batch that was not full");

  // a new result only appears after the block was busy on the closing sample
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without batch-end work");

endmodule

bind linear_regression_gradient_step lrgs_checker #(.MAX_BATCH(MAX_BATCH)) u_lrgs_checker (.*);
